@@ rtl/button_gesture_motor_mode_control_core_assert.svh @@
// Assertion macros shared by the gesture core checker.
// No dependencies; include by bare file name.
`ifndef BUTTON_GESTURE_MOTOR_MODE_CONTROL_CORE_ASSERT_SVH
`define BUTTON_GESTURE_MOTOR_MODE_CONTROL_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define BGMM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bgmm check failed");

// Next-cycle implication, disabled during reset.
`define BGMM_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bgmm check failed");

`endif

@@ rtl/bgmm_pkg.sv @@
// Shared types, codes and constants of the button gesture motor mode core.
// No dependencies.
package bgmm_pkg;

  localparam int unsigned TimeWidth = 32;
  localparam int unsigned RegAddrW  = 3;

  typedef logic [TimeWidth-1:0] time_t;

  localparam logic [1:0] KEY_PRESS   = 2'd1;
  localparam logic [1:0] KEY_RELEASE = 2'd2;

  localparam logic REG_LONG_PRESS = 1'b0;
  localparam logic REG_CLICK_GAP  = 1'b1;

  localparam logic [15:0] LONG_PRESS_RST = 16'd3000;
  localparam logic [15:0] CLICK_GAP_RST  = 16'd500;
  localparam logic [3:0]  GEAR_RST       = 4'd1;
  localparam logic [1:0]  CLICK_MAX      = 2'd3;

  localparam logic [7:0] ASCII_ZERO = 8'h30;
  localparam logic [7:0] ASCII_ONE  = 8'h31;
  localparam logic [7:0] ASCII_NINE = 8'h39;

  typedef enum logic [1:0] {
    MODE_FWD  = 2'd0,
    MODE_BACK = 2'd1,
    MODE_STOP = 2'd2,
    MODE_END  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    CMD_NONE = 2'd0,
    CMD_STOP = 2'd1,
    CMD_CW   = 2'd2,
    CMD_CCW  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    LED_NONE  = 2'd0,
    LED_BLINK = 2'd1,
    LED_ON    = 2'd2
  } led_e;

  typedef struct packed {
    logic [15:0] long_press;
    logic [15:0] click_gap;
  } cfg_t;

  typedef struct packed {
    logic [31:0] now;
    logic [1:0]  key_event;
    logic        uart_valid;
    logic [7:0]  uart_byte;
  } item_t;

  typedef struct packed {
    cmd_e       motor_cmd;
    logic [3:0] gear;
    led_e       led;
    mode_e      mode;
  } result_t;

endpackage

@@ rtl/bgmm_apb_regs.sv @@
// APB-style configuration registers: long press and click gap thresholds.
// Depends on bgmm_pkg.
module bgmm_apb_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [bgmm_pkg::RegAddrW-1:0]   paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  output bgmm_pkg::cfg_t                  cfg_o
);

  logic        wr_en;
  logic [15:0] long_press_q, long_press_d;
  logic [15:0] click_gap_q, click_gap_d;
  logic [15:0] rd_val;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    long_press_d = long_press_q;
    click_gap_d  = click_gap_q;
    if (wr_en) begin
      case (paddr[2])
        bgmm_pkg::REG_LONG_PRESS: long_press_d = pwdata[15:0];
        bgmm_pkg::REG_CLICK_GAP:  click_gap_d  = pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      bgmm_pkg::REG_LONG_PRESS: rd_val = long_press_q;
      bgmm_pkg::REG_CLICK_GAP:  rd_val = click_gap_q;
      default:                  rd_val = '0;
    endcase
  end

  assign prdata = {16'b0, rd_val};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_press_q <= bgmm_pkg::LONG_PRESS_RST;
      click_gap_q  <= bgmm_pkg::CLICK_GAP_RST;
    end else begin
      long_press_q <= long_press_d;
      click_gap_q  <= click_gap_d;
    end
  end

  assign cfg_o.long_press = long_press_q;
  assign cfg_o.click_gap  = click_gap_q;

endmodule

@@ rtl/bgmm_gesture_core.sv @@
// Gesture state registers and the per-step classify / mode update logic.
// Depends on bgmm_pkg.
module bgmm_gesture_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  bgmm_pkg::item_t   item_i,
  input  bgmm_pkg::cfg_t    cfg_i,
  output bgmm_pkg::result_t result_o
);

  logic                held_q, held_d;
  bgmm_pkg::time_t     press_q, press_d;
  bgmm_pkg::time_t     rel_q, rel_d;
  logic [1:0]          cnt_q, cnt_d;
  bgmm_pkg::mode_e     mode_q, mode_d;
  logic [3:0]          gear_q, gear_d;

  bgmm_pkg::time_t     now_t;
  bgmm_pkg::time_t     lp_t;
  bgmm_pkg::time_t     gap_t;
  bgmm_pkg::time_t     hold_el;
  bgmm_pkg::time_t     gap_el;
  logic                is_press;
  logic                is_release;
  logic                short_rel;
  logic                digit;
  bgmm_pkg::cmd_e      cmd;
  bgmm_pkg::led_e      led;

  assign now_t      = bgmm_pkg::time_t'(item_i.now);
  assign lp_t       = bgmm_pkg::time_t'(cfg_i.long_press);
  assign gap_t      = bgmm_pkg::time_t'(cfg_i.click_gap);
  assign is_press   = (item_i.key_event == bgmm_pkg::KEY_PRESS);
  assign is_release = (item_i.key_event == bgmm_pkg::KEY_RELEASE);

  // A press restamps, so its own hold time is zero.
  assign hold_el   = is_press ? '0 : (now_t - press_q);
  assign short_rel = is_release && (hold_el < lp_t);
  // A short release restamps, so its own quiet time is zero.
  assign gap_el    = short_rel ? '0 : (now_t - rel_q);
  assign digit     = item_i.uart_valid && (item_i.uart_byte >= bgmm_pkg::ASCII_ONE)
                     && (item_i.uart_byte <= bgmm_pkg::ASCII_NINE);

  always_comb begin
    held_d  = held_q;
    press_d = press_q;
    rel_d   = rel_q;
    cnt_d   = cnt_q;
    mode_d  = mode_q;
    gear_d  = gear_q;
    cmd     = bgmm_pkg::CMD_NONE;
    led     = bgmm_pkg::LED_NONE;

    if (is_press) begin
      held_d  = 1'b1;
      press_d = now_t;
    end else if (is_release) begin
      held_d = 1'b0;
      if (short_rel) begin
        if (cnt_q != bgmm_pkg::CLICK_MAX) begin
          cnt_d = cnt_q + 2'd1;
        end
        rel_d = now_t;
      end
    end

    if (held_d && (hold_el >= lp_t)) begin
      held_d = 1'b0;
      cnt_d  = '0;
      if (mode_q != bgmm_pkg::MODE_END) begin
        cmd    = bgmm_pkg::CMD_STOP;
        led    = bgmm_pkg::LED_BLINK;
        mode_d = bgmm_pkg::MODE_END;
      end
    end else if (cnt_d >= 2'd2) begin
      cnt_d = '0;
      if (mode_q == bgmm_pkg::MODE_FWD || mode_q == bgmm_pkg::MODE_BACK) begin
        cmd    = bgmm_pkg::CMD_STOP;
        mode_d = bgmm_pkg::MODE_STOP;
      end
    end else if (cnt_d == 2'd1 && !held_d && (gap_el >= gap_t)) begin
      cnt_d = '0;
      case (mode_q)
        bgmm_pkg::MODE_STOP: begin
          cmd    = bgmm_pkg::CMD_CW;
          mode_d = bgmm_pkg::MODE_FWD;
        end
        bgmm_pkg::MODE_FWD: begin
          cmd    = bgmm_pkg::CMD_CCW;
          mode_d = bgmm_pkg::MODE_BACK;
        end
        bgmm_pkg::MODE_BACK: begin
          cmd    = bgmm_pkg::CMD_CW;
          mode_d = bgmm_pkg::MODE_FWD;
        end
        default: begin
          led    = bgmm_pkg::LED_ON;
          mode_d = bgmm_pkg::MODE_STOP;
        end
      endcase
    end

    if (digit) begin
      gear_d = 4'(item_i.uart_byte - bgmm_pkg::ASCII_ZERO);
      if (mode_d == bgmm_pkg::MODE_FWD) begin
        cmd = bgmm_pkg::CMD_CW;
      end else if (mode_d == bgmm_pkg::MODE_BACK) begin
        cmd = bgmm_pkg::CMD_CCW;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q  <= 1'b0;
      press_q <= '0;
      rel_q   <= '0;
      cnt_q   <= '0;
      mode_q  <= bgmm_pkg::MODE_STOP;
      gear_q  <= bgmm_pkg::GEAR_RST;
    end else if (step_i) begin
      held_q  <= held_d;
      press_q <= press_d;
      rel_q   <= rel_d;
      cnt_q   <= cnt_d;
      mode_q  <= mode_d;
      gear_q  <= gear_d;
    end
  end

  assign result_o.motor_cmd = cmd;
  assign result_o.gear      = gear_d;
  assign result_o.led       = led;
  assign result_o.mode      = mode_d;

endmodule

@@ rtl/button_gesture_motor_mode_control_core.sv @@
// Button gesture motor mode control core: top level.
// An accepted word passes the input register, then the result register.
// Throughput: one word per cycle unless out_stall_i holds it; the gesture state
// updates as a word moves from the input register through the classify logic
// into the result register.
// Reset (rst_ni low, asynchronous): both stages empty, mode STOP, gear 1,
// thresholds back to 3000 and 500 ticks.
module button_gesture_motor_mode_control_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [31:0]                   now_i,
  input  logic [1:0]                    key_event_i,
  input  logic                          uart_valid_i,
  input  logic [7:0]                    uart_byte_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [1:0]                    motor_cmd_o,
  output logic [3:0]                    cmd_gear_o,
  output logic [1:0]                    led_action_o,
  output logic [1:0]                    mode_o,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bgmm_pkg::RegAddrW-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  bgmm_pkg::cfg_t    cfg;
  bgmm_pkg::item_t   in_item;
  bgmm_pkg::item_t   s1_item_q;
  logic              s1_valid_q, s1_valid_d;
  bgmm_pkg::result_t step_res;
  bgmm_pkg::result_t out_q;
  logic              out_valid_q, out_valid_d;
  logic              in_acc;
  logic              adv;

  bgmm_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Advance the input word into the result register whenever that slot is
  // free or being drained this cycle.
  assign adv        = s1_valid_q && (!out_valid_q || !out_stall_i);
  // Stall only when the input register is full and cannot move on.
  assign in_stall_o = s1_valid_q && !adv;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign in_item.now        = now_i;
  assign in_item.key_event  = key_event_i;
  assign in_item.uart_valid = uart_valid_i;
  assign in_item.uart_byte  = uart_byte_i;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_acc) begin
      s1_valid_d = 1'b1;
    end else if (adv) begin
      s1_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (adv) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers: hold unless loaded.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_item_q <= in_item;
    end
    if (adv) begin
      out_q <= step_res;
    end
  end

  // Gesture state commits exactly when its word advances.
  bgmm_gesture_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (adv),
    .item_i   (s1_item_q),
    .cfg_i    (cfg),
    .result_o (step_res)
  );

  assign out_valid_o  = out_valid_q;
  assign motor_cmd_o  = out_q.motor_cmd;
  assign cmd_gear_o   = out_q.gear;
  assign led_action_o = out_q.led;
  assign mode_o       = out_q.mode;

endmodule

@@ rtl/bgmm_checker.sv @@
// Port-level checker for the gesture core, bound to the top level.
// Depends on bgmm_pkg and the assertion macro header.
`include "button_gesture_motor_mode_control_core_assert.svh"

module bgmm_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [1:0]                    motor_cmd_o,
  input logic [3:0]                    cmd_gear_o,
  input logic [1:0]                    led_action_o,
  input logic [1:0]                    mode_o
);

  // A stalled result word stays put.
  `BGMM_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
    out_valid_o && $stable(motor_cmd_o) && $stable(cmd_gear_o) && $stable(mode_o))
  // A drive command always matches the mode it leaves behind.
  `BGMM_ASSERT_IMP(a_cmd_mode, clk_i, rst_ni,
    out_valid_o && (motor_cmd_o == bgmm_pkg::CMD_CW || motor_cmd_o == bgmm_pkg::CMD_CCW),
    (motor_cmd_o == bgmm_pkg::CMD_CW && mode_o == bgmm_pkg::MODE_FWD) ||
    (motor_cmd_o == bgmm_pkg::CMD_CCW && mode_o == bgmm_pkg::MODE_BACK))
  // Blink only comes with the long press stop into END.
  `BGMM_ASSERT_IMP(a_blink_end, clk_i, rst_ni,
    out_valid_o && led_action_o == bgmm_pkg::LED_BLINK,
    motor_cmd_o == bgmm_pkg::CMD_STOP && mode_o == bgmm_pkg::MODE_END)
  // Gear stays within the digit range.
  `BGMM_ASSERT_IMP(a_gear_range, clk_i, rst_ni, out_valid_o,
    cmd_gear_o >= 4'd1 && cmd_gear_o <= 4'd9)

endmodule

bind button_gesture_motor_mode_control_core bgmm_checker u_bgmm_checker (.*);
